[sv/pidc_pkg.sv]
// pidc_pkg: widths, register indices and derived sizes for the PID step block.
// Stand-alone; imported by pid_controller_step.
package pidc_pkg;

    localparam int DATA_WIDTH = 16;   // setpoint / measurement width
    localparam int ACC_WIDTH  = 40;   // integral accumulator width, Q.8
    localparam int GAIN_W     = 16;   // gain and period register width
    localparam int DRIVE_W    = 24;   // drive output width
    localparam int CFG_IDX_W  = 8;    // config register index width

    // register indices
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD = CFG_IDX_W'(3);

    // derived widths
    localparam int ERR_W     = DATA_WIDTH + 1;          // setpoint - measurement
    localparam int DERR_W    = DATA_WIDTH + 2;          // error - previous error
    localparam int DMAG_IN_W = DATA_WIDTH + 1;          // |error delta|
    localparam int PROD_W    = ERR_W + GAIN_W;          // signed P / I product
    localparam int DMAG_W    = DMAG_IN_W + GAIN_W;      // |D product|, also quotient
    localparam int SUM_BASE  = (ACC_WIDTH > DMAG_W + 1) ?
                               ((ACC_WIDTH > PROD_W) ? ACC_WIDTH : PROD_W) :
                               ((DMAG_W + 1 > PROD_W) ? DMAG_W + 1 : PROD_W);
    localparam int SUM_W     = SUM_BASE + 2;            // P + I + D, no overflow
    localparam int CNT_W     = $clog2(DMAG_W);          // bit counter

endpackage

[sv/pid_controller_step.sv]
// pid_controller_step: discrete PID regulator with bit-serial multiply and divide.
// Depends on pidc_pkg for widths and register indices.
//
// Usage
// - Config channel (i_cfg_valid / o_cfg_ready, always ready): i_cfg_index selects
//   gain_p (0), gain_i (1), gain_d (2) or sample_period (3); other indices are
//   ignored. Write only while the block is idle. A period of zero divides by one.
// - Input channel (i_in_valid / o_in_ready): one word holds a setpoint and a
//   measurement. o_in_ready is high only while no sample is being worked on.
// - Output channel (o_out_valid / i_out_ready): one word per sample, the
//   saturated drive and a flag set when the integral or the drive was clamped.
// Steps: a sample passes through a shift-add multiply (one gain bit per cycle,
// three lanes side by side), the integral clamp, the P + I sum, a restoring
// divide (one quotient bit per cycle), the sign restore of D and the final
// sum and drive clamp. The result sits in an output register, so the
// next sample is taken while an earlier word is still unclaimed; the final
// step waits only if that register is still full.
// Reset (synchronous, active low) clears gains, sets the period to one,
// zeroes the integral and the previous error and empties the output.

module pid_controller_step (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // config write channel
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [pidc_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [pidc_pkg::GAIN_W-1:0]            i_cfg_data,
    // sample input
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic signed [pidc_pkg::DATA_WIDTH-1:0] i_setpoint,
    input  logic signed [pidc_pkg::DATA_WIDTH-1:0] i_measurement,
    // result output
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [pidc_pkg::DRIVE_W-1:0]    o_drive,
    output logic                                   o_saturated
);
    import pidc_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;   // waiting for a sample
    localparam logic [2:0] S_MUL  = 3'd1;   // shift-add, one gain bit a cycle
    localparam logic [2:0] S_INT  = 3'd2;   // integral update and clamp
    localparam logic [2:0] S_PI   = 3'd3;   // P + I
    localparam logic [2:0] S_DIV  = 3'd4;   // restoring divide, one bit a cycle
    localparam logic [2:0] S_NEG  = 3'd5;   // restore sign of D
    localparam logic [2:0] S_FIN  = 3'd6;   // final sum, scale, clamp

    localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};
    localparam logic signed [DRIVE_W-1:0]   DRV_MAX = {1'b0, {(DRIVE_W-1){1'b1}}};
    localparam logic signed [DRIVE_W-1:0]   DRV_MIN = {1'b1, {(DRIVE_W-1){1'b0}}};

    // config registers
    logic signed [GAIN_W-1:0]    r_gain_p, r_gain_i, r_gain_d;
    logic        [GAIN_W-1:0]    r_period;

    // kept state
    logic signed [ACC_WIDTH-1:0] r_int;
    logic signed [ERR_W-1:0]     r_prev_err;

    // sequencer
    logic [2:0]                  r_state;
    logic [CNT_W-1:0]            r_cnt;

    // multiply lanes: P and I share the error as multiplicand, D works on magnitudes
    logic signed [PROD_W-1:0]    r_mc_pi;
    logic signed [PROD_W-1:0]    r_acc_p, r_acc_i;
    logic        [GAIN_W-1:0]    r_gsh_p, r_gsh_i, r_gsh_d;
    logic        [DMAG_W-1:0]    r_mc_d;
    logic        [DMAG_W-1:0]    r_dq;        // D product, then dividend / quotient
    logic                        r_d_neg;

    // divider
    logic        [GAIN_W-1:0]    r_divisor;
    logic        [GAIN_W-1:0]    r_rem;

    logic signed [SUM_W-1:0]     r_sum;
    logic signed [DMAG_W:0]      r_dterm;
    logic                        r_sat;

    // output register
    logic                        r_out_valid;
    logic signed [DRIVE_W-1:0]   r_drive;
    logic                        r_out_sat;

    // ---- combinational helpers ----
    logic                        w_in_acc;
    logic signed [ERR_W-1:0]     w_err;
    logic signed [DERR_W-1:0]    w_derr;
    logic signed [DERR_W-1:0]    w_derr_neg;
    logic        [DMAG_IN_W-1:0] w_derr_mag;
    logic signed [GAIN_W-1:0]    w_gd_neg;
    logic        [GAIN_W-1:0]    w_gd_mag;

    logic                        w_mul_last;
    logic signed [PROD_W-1:0]    w_mc_sel;
    logic signed [PROD_W-1:0]    w_pp_p, w_pp_i;
    logic        [DMAG_W-1:0]    w_pp_d;

    logic signed [ACC_WIDTH:0]   w_int_sum;
    logic                        w_int_ovf;
    logic signed [ACC_WIDTH-1:0] n_int;

    logic        [GAIN_W:0]      w_trial;
    logic        [GAIN_W:0]      w_diff;
    logic                        w_ge;
    logic                        w_div_last;

    logic signed [SUM_W-1:0]     w_total;
    logic [SUM_W-DRIVE_W-8:0]    w_hi;
    logic                        w_fits;
    logic signed [DRIVE_W-1:0]   n_drive;
    logic                        w_fin_go;

    assign w_in_acc   = i_in_valid && o_in_ready;

    assign w_err      = ERR_W'(i_setpoint) - ERR_W'(i_measurement);
    assign w_derr     = DERR_W'(w_err) - DERR_W'(r_prev_err);
    assign w_derr_neg = -w_derr;
    assign w_derr_mag = w_derr[DERR_W-1] ? DMAG_IN_W'(w_derr_neg) : DMAG_IN_W'(w_derr);
    assign w_gd_neg   = -r_gain_d;
    assign w_gd_mag   = r_gain_d[GAIN_W-1] ? GAIN_W'(w_gd_neg) : GAIN_W'(r_gain_d);

    // gain sign bit has weight -2^(GAIN_W-1)
    assign w_mul_last = (r_cnt == CNT_W'(GAIN_W-1));
    assign w_mc_sel   = w_mul_last ? -r_mc_pi : r_mc_pi;
    assign w_pp_p     = r_gsh_p[0] ? w_mc_sel : '0;
    assign w_pp_i     = r_gsh_i[0] ? w_mc_sel : '0;
    assign w_pp_d     = r_gsh_d[0] ? r_mc_d : '0;

    assign w_int_sum  = (ACC_WIDTH+1)'(r_int) + (ACC_WIDTH+1)'(r_acc_i);
    assign w_int_ovf  = w_int_sum[ACC_WIDTH] != w_int_sum[ACC_WIDTH-1];
    assign n_int      = w_int_ovf ? (w_int_sum[ACC_WIDTH] ? ACC_MIN : ACC_MAX)
                                  : w_int_sum[ACC_WIDTH-1:0];

    assign w_trial    = {r_rem, r_dq[DMAG_W-1]};
    assign w_ge       = w_trial >= {1'b0, r_divisor};
    assign w_diff     = w_trial - {1'b0, r_divisor};
    assign w_div_last = (r_cnt == CNT_W'(DMAG_W-1));

    // floor(total / 256), then clamp to the drive range
    assign w_total    = r_sum + SUM_W'(r_dterm);
    assign w_hi       = w_total[SUM_W-1:DRIVE_W+7];
    assign w_fits     = (&w_hi) || !(|w_hi);
    assign n_drive    = w_fits ? w_total[DRIVE_W+7:8]
                               : (w_total[SUM_W-1] ? DRV_MIN : DRV_MAX);
    assign w_fin_go   = (r_state == S_FIN) && (!r_out_valid || i_out_ready);

    // ---- config registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p <= '0;
            r_gain_i <= '0;
            r_gain_d <= '0;
            r_period <= GAIN_W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_GAIN_P: r_gain_p <= i_cfg_data;
                REG_GAIN_I: r_gain_i <= i_cfg_data;
                REG_GAIN_D: r_gain_d <= i_cfg_data;
                REG_PERIOD: r_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---- control state ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_int       <= '0;
            r_prev_err  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // word taken and no new one loaded this cycle
            if (r_out_valid && i_out_ready && !w_fin_go) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_prev_err <= w_err;
                        r_cnt      <= '0;
                        r_state    <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (w_mul_last) begin
                        r_cnt   <= '0;
                        r_state <= S_INT;
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                S_INT: begin
                    r_int   <= n_int;
                    r_state <= S_PI;
                end
                S_PI: begin
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_last) begin
                        r_cnt   <= '0;
                        r_state <= S_NEG;
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                S_NEG: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (w_fin_go) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // ---- datapath ----
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    r_mc_pi   <= PROD_W'(w_err);
                    r_mc_d    <= DMAG_W'(w_derr_mag);
                    r_acc_p   <= '0;
                    r_acc_i   <= '0;
                    r_dq      <= '0;
                    r_gsh_p   <= r_gain_p;
                    r_gsh_i   <= r_gain_i;
                    r_gsh_d   <= w_gd_mag;
                    r_d_neg   <= w_derr[DERR_W-1] ^ r_gain_d[GAIN_W-1];
                    r_divisor <= (r_period == '0) ? GAIN_W'(1) : r_period;
                end
            end
            S_MUL: begin
                r_acc_p <= r_acc_p + w_pp_p;
                r_acc_i <= r_acc_i + w_pp_i;
                r_dq    <= r_dq + w_pp_d;
                r_mc_pi <= r_mc_pi << 1;
                r_mc_d  <= r_mc_d << 1;
                r_gsh_p <= r_gsh_p >> 1;
                r_gsh_i <= r_gsh_i >> 1;
                r_gsh_d <= r_gsh_d >> 1;
            end
            S_INT: begin
                r_sat <= w_int_ovf;
            end
            S_PI: begin
                r_sum <= SUM_W'(r_acc_p) + SUM_W'(r_int);
                r_rem <= '0;
            end
            S_DIV: begin
                r_rem <= w_ge ? w_diff[GAIN_W-1:0] : w_trial[GAIN_W-1:0];
                r_dq  <= {r_dq[DMAG_W-2:0], w_ge};
            end
            S_NEG: begin
                // quotient magnitude, so truncation is toward zero
                r_dterm <= r_d_neg ? -$signed({1'b0, r_dq}) : $signed({1'b0, r_dq});
            end
            S_FIN: begin
                if (w_fin_go) begin
                    r_drive   <= n_drive;
                    r_out_sat <= r_sat || !w_fits;
                end
            end
            default: ;
        endcase
    end

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_drive     = r_drive;
    assign o_saturated = r_out_sat;

    // ---- checks ----
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_MUL) && (r_cnt == '0))
        else $error("sample accepted but multiply did not start");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_divisor))
        else $error("divider remainder not below divisor");

    a_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fin_go |=> r_out_valid && (r_state == S_IDLE))
        else $error("finished sample did not reach output register");

endmodule
